/* sv/plrf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plrf_pkg: shared types, constants and microcode for the request framer
// Holds the request/response transfer structs, device-area codes, frame
// characters, the control word layout and the control store contents.
// ----------------------------------------------------------------------------
package plrf_pkg;

	// Request and response payloads
	typedef struct packed {
		logic        req_type;
		logic [2:0]  area;
		logic [12:0] element_number;
		logic [15:0] write_value;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic       refused;
	} rsp_t;

	// Device-area codes
	localparam logic [2:0] AREA_X  = 3'd0;
	localparam logic [2:0] AREA_Y  = 3'd1;
	localparam logic [2:0] AREA_M  = 3'd2;
	localparam logic [2:0] AREA_TC = 3'd3;
	localparam logic [2:0] AREA_D  = 3'd4;
	localparam logic [2:0] AREA_TV = 3'd5;

	localparam logic REQ_WRITE = 1'b1;

	// Byte-address bases
	localparam logic [15:0] BASE_X  = 16'h0080;
	localparam logic [15:0] BASE_Y  = 16'h00A0;
	localparam logic [15:0] BASE_M  = 16'h0100;
	localparam logic [15:0] BASE_TC = 16'h00C0;
	localparam logic [15:0] BASE_D  = 16'h1000;
	localparam logic [15:0] BASE_TV = 16'h0800;

	// Byte counts
	localparam logic [1:0] LEN_BYTE = 2'd1;
	localparam logic [1:0] LEN_WORD = 2'd2;

	// Frame characters
	localparam logic [7:0] CHAR_STX  = 8'h02;
	localparam logic [7:0] CHAR_ETX  = 8'h03;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NONE = 8'h00;

	// Byte source selected by a control word
	typedef enum logic [3:0] {
		SRC_STX,
		SRC_CMD,
		SRC_ADDR_HI_H,
		SRC_ADDR_HI_L,
		SRC_ADDR_LO_H,
		SRC_ADDR_LO_L,
		SRC_ZERO,
		SRC_LEN,
		SRC_DATA_LO_H,
		SRC_DATA_LO_L,
		SRC_DATA_HI_H,
		SRC_DATA_HI_L,
		SRC_ETX,
		SRC_SUM_H,
		SRC_SUM_L,
		SRC_REFUSE
	} src_t;

	// Jump conditions, tested when the step's byte is transferred
	typedef enum logic [1:0] {
		COND_NONE,
		COND_READ,
		COND_SHORT
	} cond_t;

	typedef logic [3:0] step_t;

	typedef struct packed {
		src_t  src;
		logic  sum_en;
		logic  last;
		logic  refused;
		cond_t cond;
		step_t target;
	} ctrl_t;

	// Status from the datapath to the sequencer
	typedef struct packed {
		logic is_write;
		logic is_word;
		logic refuse;
	} flags_t;

	// Program entry points
	localparam step_t STEP_FRAME  = 4'd0;
	localparam step_t STEP_ETX    = 4'd12;
	localparam step_t STEP_REFUSE = 4'd15;

	// Upper-case hex digit for one nibble
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = CHAR_ZERO + {4'd0, nib};
		end else begin
			c = 8'h37 + {4'd0, nib};
		end
		return c;
	endfunction

	function automatic ctrl_t cw(input src_t src, input logic sum_en, input logic last,
		input logic refused, input cond_t cond, input step_t target);
		ctrl_t w;
		w.src     = src;
		w.sum_en  = sum_en;
		w.last    = last;
		w.refused = refused;
		w.cond    = cond;
		w.target  = target;
		return w;
	endfunction

	// Control store: one word per frame byte
	function automatic ctrl_t ucode(input step_t s);
		ctrl_t w;
		case (s)
			4'd0:    w = cw(SRC_STX,       1'b0, 1'b0, 1'b0, COND_NONE,  STEP_FRAME);
			4'd1:    w = cw(SRC_CMD,       1'b1, 1'b0, 1'b0, COND_NONE,  STEP_FRAME);
			4'd2:    w = cw(SRC_ADDR_HI_H, 1'b1, 1'b0, 1'b0, COND_NONE,  STEP_FRAME);
			4'd3:    w = cw(SRC_ADDR_HI_L, 1'b1, 1'b0, 1'b0, COND_NONE,  STEP_FRAME);
			4'd4:    w = cw(SRC_ADDR_LO_H, 1'b1, 1'b0, 1'b0, COND_NONE,  STEP_FRAME);
			4'd5:    w = cw(SRC_ADDR_LO_L, 1'b1, 1'b0, 1'b0, COND_NONE,  STEP_FRAME);
			4'd6:    w = cw(SRC_ZERO,      1'b1, 1'b0, 1'b0, COND_NONE,  STEP_FRAME);
			4'd7:    w = cw(SRC_LEN,       1'b1, 1'b0, 1'b0, COND_READ,  STEP_ETX);
			4'd8:    w = cw(SRC_DATA_LO_H, 1'b1, 1'b0, 1'b0, COND_NONE,  STEP_FRAME);
			4'd9:    w = cw(SRC_DATA_LO_L, 1'b1, 1'b0, 1'b0, COND_SHORT, STEP_ETX);
			4'd10:   w = cw(SRC_DATA_HI_H, 1'b1, 1'b0, 1'b0, COND_NONE,  STEP_FRAME);
			4'd11:   w = cw(SRC_DATA_HI_L, 1'b1, 1'b0, 1'b0, COND_NONE,  STEP_FRAME);
			4'd12:   w = cw(SRC_ETX,       1'b1, 1'b0, 1'b0, COND_NONE,  STEP_FRAME);
			4'd13:   w = cw(SRC_SUM_H,     1'b0, 1'b0, 1'b0, COND_NONE,  STEP_FRAME);
			4'd14:   w = cw(SRC_SUM_L,     1'b0, 1'b1, 1'b0, COND_NONE,  STEP_FRAME);
			default: w = cw(SRC_REFUSE,    1'b0, 1'b1, 1'b1, COND_NONE,  STEP_FRAME);
		endcase
		return w;
	endfunction

endpackage

/* sv/plrf_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plrf_sequencer: step counter and control store
// Walks the frame program one control word per transferred byte, taking the
// conditional jumps that skip data bytes on reads and on byte writes.
// ----------------------------------------------------------------------------
module plrf_sequencer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            advance,
	input  plrf_pkg::flags_t flags,
	output plrf_pkg::ctrl_t  ctrl,
	output logic            busy
);

	logic            busy_q;
	plrf_pkg::step_t step_q;
	logic            jump;

	// Control word for the current step
	assign ctrl = plrf_pkg::ucode(step_q);
	assign busy = busy_q;

	// Jump condition
	always_comb begin
		case (ctrl.cond)
			plrf_pkg::COND_READ:  jump = !flags.is_write;
			plrf_pkg::COND_SHORT: jump = !flags.is_word;
			default:              jump = 1'b0;
		endcase
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= plrf_pkg::STEP_FRAME;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= flags.refuse ? plrf_pkg::STEP_REFUSE : plrf_pkg::STEP_FRAME;
		end else if (advance) begin
			if (ctrl.last) begin
				busy_q <= 1'b0;
			end else if (jump) begin
				step_q <= ctrl.target;
			end else begin
				step_q <= step_q + 4'd1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("request taken while a frame is in progress");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q) else $error("sequencer did not start");
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && advance && ctrl.last |=> !busy_q) else $error("sequencer ran past last byte");
`endif

endmodule

/* sv/plrf_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plrf_datapath: request latches, running sum and byte selection
// Computes the byte address on acceptance, holds the frame fields and
// produces the byte chosen by the current control word.
// ----------------------------------------------------------------------------
module plrf_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             advance,
	input  plrf_pkg::req_t   req,
	input  plrf_pkg::ctrl_t  ctrl,
	output plrf_pkg::flags_t flags,
	output logic [7:0]       frame_byte
);

	logic [15:0] addr_q;
	logic [15:0] data_q;
	logic [1:0]  len_q;
	logic        cmd_q;
	logic [7:0]  sum_q;

	logic [15:0] addr_d;
	logic [15:0] bit_base;
	logic [1:0]  len_d;
	logic        refuse;

	// Refusal: timer-value write or undefined area
	assign refuse = (req.area > plrf_pkg::AREA_TV) ||
		(req.req_type == plrf_pkg::REQ_WRITE && req.area == plrf_pkg::AREA_TV);

	// Byte address and count
	always_comb begin
		if (req.req_type == plrf_pkg::REQ_WRITE) begin
			bit_base = (req.area == plrf_pkg::AREA_M) ? plrf_pkg::BASE_M : plrf_pkg::BASE_Y;
		end else begin
			case (req.area)
				plrf_pkg::AREA_X:  bit_base = plrf_pkg::BASE_X;
				plrf_pkg::AREA_Y:  bit_base = plrf_pkg::BASE_Y;
				plrf_pkg::AREA_M:  bit_base = plrf_pkg::BASE_M;
				default:           bit_base = plrf_pkg::BASE_TC;
			endcase
		end
		case (req.area)
			plrf_pkg::AREA_D: begin
				addr_d = plrf_pkg::BASE_D + {2'd0, req.element_number, 1'b0};
				len_d  = plrf_pkg::LEN_WORD;
			end
			plrf_pkg::AREA_TV: begin
				addr_d = plrf_pkg::BASE_TV + {2'd0, req.element_number, 1'b0};
				len_d  = plrf_pkg::LEN_WORD;
			end
			default: begin
				addr_d = bit_base + {6'd0, req.element_number[12:3]};
				len_d  = plrf_pkg::LEN_BYTE;
			end
		endcase
	end

	// Frame latches and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			data_q <= '0;
			len_q  <= '0;
			cmd_q  <= 1'b0;
			sum_q  <= '0;
		end else if (start && !refuse) begin
			addr_q <= addr_d;
			data_q <= req.write_value;
			len_q  <= len_d;
			cmd_q  <= req.req_type;
			sum_q  <= '0;
		end else if (advance && ctrl.sum_en) begin
			sum_q  <= sum_q + frame_byte;
		end
	end

	assign flags.is_write = cmd_q;
	assign flags.is_word  = (len_q == plrf_pkg::LEN_WORD);
	assign flags.refuse   = refuse;

	// Byte selection
	always_comb begin
		case (ctrl.src)
			plrf_pkg::SRC_STX:       frame_byte = plrf_pkg::CHAR_STX;
			plrf_pkg::SRC_CMD:       frame_byte = plrf_pkg::CHAR_ZERO + {7'd0, cmd_q};
			plrf_pkg::SRC_ADDR_HI_H: frame_byte = plrf_pkg::hex_char(addr_q[15:12]);
			plrf_pkg::SRC_ADDR_HI_L: frame_byte = plrf_pkg::hex_char(addr_q[11:8]);
			plrf_pkg::SRC_ADDR_LO_H: frame_byte = plrf_pkg::hex_char(addr_q[7:4]);
			plrf_pkg::SRC_ADDR_LO_L: frame_byte = plrf_pkg::hex_char(addr_q[3:0]);
			plrf_pkg::SRC_ZERO:      frame_byte = plrf_pkg::CHAR_ZERO;
			plrf_pkg::SRC_LEN:       frame_byte = plrf_pkg::CHAR_ZERO + {6'd0, len_q};
			plrf_pkg::SRC_DATA_LO_H: frame_byte = plrf_pkg::hex_char(data_q[7:4]);
			plrf_pkg::SRC_DATA_LO_L: frame_byte = plrf_pkg::hex_char(data_q[3:0]);
			plrf_pkg::SRC_DATA_HI_H: frame_byte = plrf_pkg::hex_char(data_q[15:12]);
			plrf_pkg::SRC_DATA_HI_L: frame_byte = plrf_pkg::hex_char(data_q[11:8]);
			plrf_pkg::SRC_ETX:       frame_byte = plrf_pkg::CHAR_ETX;
			plrf_pkg::SRC_SUM_H:     frame_byte = plrf_pkg::hex_char(sum_q[7:4]);
			plrf_pkg::SRC_SUM_L:     frame_byte = plrf_pkg::hex_char(sum_q[3:0]);
			default:                 frame_byte = plrf_pkg::CHAR_NONE;
		endcase
	end

endmodule

/* sv/plc_link_request_framer.sv */
`timescale 1ns / 1ps
// An accepted request starts the sequencer, which then puts the first byte in the output register.
// Frame length: a read frame is 11 bytes, a bit write 13, a word write 15, a refusal 1; one byte
//   per cycle while the output is not stalled, set by the sequencer's single step per byte.
// The next request is taken once the final byte has entered the output register.
// Reset: arst_n clears the sequencer, output valid and the frame latches asynchronously.
// ----------------------------------------------------------------------------
// plc_link_request_framer: ASCII request frame builder for a controller link
// Accepts read/write requests and emits STX, command, hex address, count,
// optional hex data, ETX and a two-digit hex checksum, one byte per transfer; refusals get one byte.
// ----------------------------------------------------------------------------
module plc_link_request_framer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  plrf_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output plrf_pkg::rsp_t rsp
);

	plrf_pkg::ctrl_t  ctrl;
	plrf_pkg::flags_t flags;
	logic             busy;
	logic             start;
	logic             advance;
	logic [7:0]       frame_byte;
	logic             rsp_valid_q;
	plrf_pkg::rsp_t   rsp_q;

	// Handshake: one request at a time, bytes flow when the output slot frees
	assign req_stall = busy;
	assign start     = req_valid && !busy;
	assign advance   = busy && (!rsp_valid_q || !rsp_stall);

	plrf_sequencer u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.advance (advance),
		.flags   (flags),
		.ctrl    (ctrl),
		.busy    (busy)
	);

	plrf_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.advance    (advance),
		.req        (req),
		.ctrl       (ctrl),
		.flags      (flags),
		.frame_byte (frame_byte)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.out_byte <= frame_byte;
			rsp_q.last     <= ctrl.last;
			rsp_q.refused  <= ctrl.refused;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	a_refuse_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.refused |-> rsp_q.last) else $error("refusal not marked last");
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_stall |=> rsp_valid_q)
		else $error("stalled byte dropped");
	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_stall |=> $stable(rsp_q))
		else $error("stalled byte changed");
`endif

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the controller link request framer
// A directed table of requests runs first, followed by random requests in
// three idle phases. Every frame byte is checked against a frame builder
// kept in the bench, and a watchdog ends a run that stops making progress.
// ----------------------------------------------------------------------------
module tb_top;
	import plrf_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 9;
	localparam int RAND_PER_PHASE = 120;
	localparam int SETTLE_CYCLES  = 20;
	localparam int STUCK_LIMIT    = 2000;
	localparam int NUM_MAX        = 8191;

	// Answer to a request that has no frame
	localparam rsp_t REFUSAL_RSP = '{out_byte: CHAR_NONE, last: 1'b1, refused: 1'b1};

	typedef struct {
		req_t r;
		logic lit;
		rsp_t lit_rsp;
	} dir_row_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Frame latches of the bench's own frame builder
	logic [15:0] frame_addr;
	logic [15:0] frame_data;
	logic [1:0]  frame_len;
	logic        frame_cmd;
	logic [7:0]  frame_sum;

	rsp_t     expected_bytes[$];
	dir_row_t directed_reqs[$];
	int       send_idle_pct = 9;
	int       rcv_idle_pct  = 51;
	int       stuck_cycles  = 0;
	int       err_count     = 0;
	logic     timed_out     = 1'b0;

	plc_link_request_framer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ASCII for one hex nibble, upper case
	function automatic logic [7:0] nib_to_ascii(input logic [3:0] n);
		if (n < 4'd10) begin
			return CHAR_ZERO + {4'd0, n};
		end
		return 8'h41 + {4'd0, n} - 8'd10;
	endfunction

	function automatic void emit_byte(input logic [7:0] b, input logic summed, input logic lst);
		if (summed) begin
			frame_sum = frame_sum + b;
		end
		expected_bytes.push_back('{out_byte: b, last: lst, refused: 1'b0});
	endfunction

	function automatic void emit_hex(input logic [7:0] v);
		emit_byte(nib_to_ascii(v[7:4]), 1'b1, 1'b0);
		emit_byte(nib_to_ascii(v[3:0]), 1'b1, 1'b0);
	endfunction

	// Queue every byte that one accepted request should put on the link
	function automatic void predict_frame(input req_t r);
		logic [15:0] base;
		logic [7:0]  s;
		if (r.area > AREA_TV || (r.req_type == REQ_WRITE && r.area == AREA_TV)) begin
			// no frame; latches keep the last frame
			expected_bytes.push_back(REFUSAL_RSP);
			return;
		end
		case (r.area)
			AREA_D: begin
				frame_addr = BASE_D + {2'b00, r.element_number, 1'b0};
				frame_len  = LEN_WORD;
			end
			AREA_TV: begin
				frame_addr = BASE_TV + {2'b00, r.element_number, 1'b0};
				frame_len  = LEN_WORD;
			end
			default: begin
				// bit writes land in M, or in Y for every other bit area
				if (r.req_type == REQ_WRITE) begin
					base = (r.area == AREA_M) ? BASE_M : BASE_Y;
				end else begin
					case (r.area)
						AREA_X:  base = BASE_X;
						AREA_Y:  base = BASE_Y;
						AREA_M:  base = BASE_M;
						default: base = BASE_TC;
					endcase
				end
				frame_addr = base + {6'd0, r.element_number[12:3]};
				frame_len  = LEN_BYTE;
			end
		endcase
		frame_data = r.write_value;
		frame_cmd  = r.req_type;
		frame_sum  = 8'd0;

		emit_byte(CHAR_STX, 1'b0, 1'b0);
		emit_byte(CHAR_ZERO + {7'd0, frame_cmd}, 1'b1, 1'b0);
		emit_hex(frame_addr[15:8]);
		emit_hex(frame_addr[7:0]);
		emit_byte(CHAR_ZERO, 1'b1, 1'b0);
		emit_byte(CHAR_ZERO + {6'd0, frame_len}, 1'b1, 1'b0);
		if (frame_cmd == REQ_WRITE) begin
			emit_hex(frame_data[7:0]);
			if (frame_len == LEN_WORD) begin
				emit_hex(frame_data[15:8]);
			end
		end
		emit_byte(CHAR_ETX, 1'b1, 1'b0);
		s = frame_sum;
		emit_byte(nib_to_ascii(s[7:4]), 1'b0, 1'b0);
		emit_byte(nib_to_ascii(s[3:0]), 1'b0, 1'b1);
	endfunction

	function automatic dir_row_t dir_row(input logic rt, input logic [2:0] ar,
		input logic [12:0] num, input logic [15:0] val, input logic lit, input rsp_t lr);
		dir_row_t d;
		d.r.req_type       = rt;
		d.r.area           = ar;
		d.r.element_number = num;
		d.r.write_value    = val;
		d.lit              = lit;
		d.lit_rsp          = lr;
		return d;
	endfunction

	// Mostly well-formed requests, some refusals, element numbers biased to the ends
	function automatic req_t rand_request();
		req_t        r;
		int unsigned pick;
		int unsigned tmp;
		pick = $urandom_range(99);
		tmp = $urandom_range(1);
		r.req_type = tmp[0];
		tmp = $urandom_range(5);
		r.area = tmp[2:0];
		if (pick < 8) begin
			tmp = $urandom_range(7, 6);
			r.area = tmp[2:0];
		end else if (pick < 12) begin
			r.req_type = REQ_WRITE;
			r.area     = AREA_TV;
		end else if (r.req_type == REQ_WRITE && r.area == AREA_TV) begin
			r.req_type = ~REQ_WRITE;
		end
		case ($urandom_range(3))
			0:       tmp = 0;
			1:       tmp = NUM_MAX;
			default: tmp = $urandom_range(NUM_MAX);
		endcase
		r.element_number = tmp[12:0];
		tmp = $urandom_range(16'hFFFF);
		r.write_value = tmp[15:0];
		return r;
	endfunction

	// Present one request, with a random idle gap first, and wait for its transfer
	task automatic send_req(input req_t r, input logic lit, input rsp_t lit_rsp);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		if (lit) begin
			expected_bytes.push_back(lit_rsp);
		end else begin
			predict_frame(r);
		end
	endtask

	// Receiver: check each byte transfer, stall at random, watch for progress
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_bytes.size() == 0) begin
				$error("unexpected byte %h last %b refused %b", rsp.out_byte, rsp.last,
					rsp.refused);
				err_count++;
			end else begin
				if (rsp.out_byte !== expected_bytes[0].out_byte) begin
					$error("out_byte: expected %h, got %h", expected_bytes[0].out_byte,
						rsp.out_byte);
					err_count++;
				end
				if (rsp.last !== expected_bytes[0].last) begin
					$error("last: expected %b, got %b", expected_bytes[0].last, rsp.last);
					err_count++;
				end
				if (rsp.refused !== expected_bytes[0].refused) begin
					$error("refused: expected %b, got %b", expected_bytes[0].refused,
						rsp.refused);
					err_count++;
				end
				void'(expected_bytes.pop_front());
			end
		end
		rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
		if (arst_n && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		directed_reqs = '{
			// reads of every area, most at both ends of the element range
			dir_row(1'b0, AREA_X,  13'd0,    16'h0000, 1'b0, REFUSAL_RSP),
			dir_row(1'b0, AREA_X,  13'd8191, 16'hFFFF, 1'b0, REFUSAL_RSP),
			dir_row(1'b0, AREA_Y,  13'd0,    16'h0000, 1'b0, REFUSAL_RSP),
			dir_row(1'b0, AREA_Y,  13'd8191, 16'h0000, 1'b0, REFUSAL_RSP),
			dir_row(1'b0, AREA_M,  13'd8191, 16'h0000, 1'b0, REFUSAL_RSP),
			dir_row(1'b0, AREA_TC, 13'd7,    16'h0000, 1'b0, REFUSAL_RSP),
			dir_row(1'b0, AREA_D,  13'd0,    16'h0000, 1'b0, REFUSAL_RSP),
			dir_row(1'b0, AREA_D,  13'd8191, 16'h0000, 1'b0, REFUSAL_RSP),
			dir_row(1'b0, AREA_TV, 13'd0,    16'h0000, 1'b0, REFUSAL_RSP),
			dir_row(1'b0, AREA_TV, 13'd8191, 16'h0000, 1'b0, REFUSAL_RSP),
			// bit writes: M stays M, other bit areas go to Y
			dir_row(1'b1, AREA_X,  13'd0,    16'h00FF, 1'b0, REFUSAL_RSP),
			dir_row(1'b1, AREA_Y,  13'd8191, 16'hAB00, 1'b0, REFUSAL_RSP),
			dir_row(1'b1, AREA_M,  13'd8191, 16'hFFFF, 1'b0, REFUSAL_RSP),
			dir_row(1'b1, AREA_TC, 13'd8,    16'h12A5, 1'b0, REFUSAL_RSP),
			// word writes
			dir_row(1'b1, AREA_D,  13'd0,    16'h0000, 1'b0, REFUSAL_RSP),
			dir_row(1'b1, AREA_D,  13'd8191, 16'hFFFF, 1'b0, REFUSAL_RSP),
			dir_row(1'b1, AREA_D,  13'd100,  16'h1234, 1'b0, REFUSAL_RSP),
			// timer-value write and unused area codes are refused
			dir_row(1'b1, AREA_TV, 13'd0,    16'hFFFF, 1'b1, REFUSAL_RSP),
			dir_row(1'b0, 3'd6,    13'd0,    16'h0000, 1'b1, REFUSAL_RSP),
			dir_row(1'b1, 3'd6,    13'd8191, 16'hFFFF, 1'b1, REFUSAL_RSP),
			dir_row(1'b0, 3'd7,    13'd8191, 16'h0000, 1'b1, REFUSAL_RSP),
			dir_row(1'b1, 3'd7,    13'd0,    16'h5A5A, 1'b1, REFUSAL_RSP),
			// refusal must not disturb the next frame
			dir_row(1'b1, AREA_D,  13'd4095, 16'h8001, 1'b0, REFUSAL_RSP)
		};
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		fork
			begin
				for (int p = 0; p < 3; p++) begin
					case (p)
						0: begin
							send_idle_pct = 9;
							rcv_idle_pct  = 51;
						end
						1: begin
							send_idle_pct = 51;
							rcv_idle_pct  = 9;
						end
						default: begin
							send_idle_pct = 0;
							rcv_idle_pct  = 0;
						end
					endcase
					if (p == 0) begin
						foreach (directed_reqs[i]) begin
							send_req(directed_reqs[i].r, directed_reqs[i].lit,
								directed_reqs[i].lit_rsp);
						end
					end
					for (int k = 0; k < RAND_PER_PHASE; k++) begin
						send_req(rand_request(), 1'b0, REFUSAL_RSP);
					end
					// hold off until the link has drained
					req_valid <= 1'b0;
					@(posedge clk);
					while (expected_bytes.size() != 0) @(posedge clk);
				end
				repeat (SETTLE_CYCLES) @(posedge clk);
			end
			begin
				wait (stuck_cycles >= STUCK_LIMIT);
				timed_out = 1'b1;
			end
		join_any

		if (expected_bytes.size() != 0) begin
			$error("%0d frame bytes never arrived", expected_bytes.size());
			err_count++;
		end
		if (!timed_out && err_count == 0) begin
			$display("plc_link_request_framer test passed");
		end else begin
			$display("plc_link_request_framer test failed");
		end
		$finish;
	end

endmodule
